// File: hw/rtl/spf_pkg.sv
// Shared types and constants for the serial packet framer.
`timescale 1ns / 1ps

package spf_pkg;

  // command field codes
  localparam logic CMD_BEGIN   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  // frame header magic bytes
  localparam logic [7:0] MAGIC_FIRST  = 8'hCC;
  localparam logic [7:0] MAGIC_SECOND = 8'h57;

  // most bytes that one input word can cause (header plus checksum)
  localparam int MAX_RESULTS = 6;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic       command;
    logic [7:0] payload_length;
    logic [7:0] packet_code;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       last;
    logic       error;
  } out_word_t;

  // all results of one input word, slot 0 goes out first
  typedef struct packed {
    logic [CNT_W-1:0]                  count;
    out_word_t [MAX_RESULTS-1:0]       slot;
  } burst_t;

endpackage

// File: hw/rtl/spf_core.sv
// Framing state and the result burst for one input word.
`timescale 1ns / 1ps

module spf_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  spf_pkg::in_word_t item,
  output spf_pkg::burst_t   burst
);

  logic [7:0] seq_r, seq_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       open_r, open_nxt;

  logic [7:0] hdr_sum;
  logic [7:0] pay_sum;
  logic [7:0] pay_remain;

  assign hdr_sum    = item.payload_length + item.packet_code;
  assign pay_sum    = sum_r + item.data_byte;
  assign pay_remain = remain_r - 8'd1;

  // build the burst and the next framing state
  always_comb begin
    seq_nxt    = seq_r;
    remain_nxt = remain_r;
    sum_nxt    = sum_r;
    open_nxt   = open_r;
    burst      = '0;

    if (item.command == spf_pkg::CMD_BEGIN) begin
      burst.slot[0].out_byte = spf_pkg::MAGIC_FIRST;
      burst.slot[1].out_byte = spf_pkg::MAGIC_SECOND;
      burst.slot[2].out_byte = seq_r;
      burst.slot[3].out_byte = item.payload_length;
      burst.slot[4].out_byte = item.packet_code;
      seq_nxt    = seq_r + 8'd1;
      remain_nxt = item.payload_length;
      if (item.payload_length == 8'd0) begin
        // empty packet: checksum follows the header at once
        burst.count             = spf_pkg::CNT_W'(6);
        burst.slot[5].out_byte  = hdr_sum;
        burst.slot[5].frame_end = 1'b1;
        burst.slot[5].last      = 1'b1;
        sum_nxt  = 8'd0;
        open_nxt = 1'b0;
      end else begin
        burst.count        = spf_pkg::CNT_W'(5);
        burst.slot[4].last = 1'b1;
        sum_nxt  = hdr_sum;
        open_nxt = 1'b1;
      end
    end else if (!open_r) begin
      // stray payload byte
      burst.count         = spf_pkg::CNT_W'(1);
      burst.slot[0].last  = 1'b1;
      burst.slot[0].error = 1'b1;
    end else begin
      burst.slot[0].out_byte = item.data_byte;
      remain_nxt = pay_remain;
      if (pay_remain == 8'd0) begin
        // closing byte, then checksum
        burst.count             = spf_pkg::CNT_W'(2);
        burst.slot[1].out_byte  = pay_sum;
        burst.slot[1].frame_end = 1'b1;
        burst.slot[1].last      = 1'b1;
        sum_nxt  = 8'd0;
        open_nxt = 1'b0;
      end else begin
        burst.count        = spf_pkg::CNT_W'(1);
        burst.slot[0].last = 1'b1;
        sum_nxt = pay_sum;
      end
    end
  end

  // state advances when a word moves into the burst register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r    <= 8'd0;
      remain_r <= 8'd0;
      sum_r    <= 8'd0;
      open_r   <= 1'b0;
    end else if (load) begin
      seq_r    <= seq_nxt;
      remain_r <= remain_nxt;
      sum_r    <= sum_nxt;
      open_r   <= open_nxt;
    end
  end

  // an open packet always has bytes left to come
  a_open_has_remain: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> remain_r != 8'd0)
    else $error("open packet with no bytes remaining");

  // the running sum is cleared whenever no packet is open
  a_closed_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !open_r |-> sum_r == 8'd0)
    else $error("running sum not cleared on closed packet");

  // every begin moves the sequence number by one
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    load && item.command == spf_pkg::CMD_BEGIN |=> seq_r == $past(seq_r) + 8'd1)
    else $error("sequence number did not step on begin");

endmodule

// File: hw/rtl/serial_packet_framer.sv
// Top level of the serial packet framer: input register, burst register, output.
`timescale 1ns / 1ps

// Channel  Direction  Ports                         Word
// in       input      in_valid, in_stall, in_data   spf_pkg::in_word_t
// out      output     out_valid, out_stall, out_data spf_pkg::out_word_t
//
// A payload word yields one byte (two when it closes the packet); a begin word
// yields five (six for an empty packet); the output sends one byte a cycle unless
// out_stall is high. A word's first byte shows after the input register and then
// the burst register; payload words stream one per cycle while out_stall is low.
// Reset (synchronous, rst_n low) clears sequence number, checksum and open flag.
// out_stall holds the current byte; the input stalls only once its register is full.

module serial_packet_framer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spf_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output spf_pkg::out_word_t out_data
);

  logic                         hold_valid_r, hold_valid_nxt;
  spf_pkg::in_word_t            hold_r;
  logic [spf_pkg::CNT_W-1:0]    cnt_r;
  spf_pkg::out_word_t [spf_pkg::MAX_RESULTS-1:0] slot_r;

  spf_pkg::burst_t burst;
  logic            out_take;
  logic            burst_free;
  logic            load;
  logic            in_accept;

  // handshake
  assign out_valid  = cnt_r != '0;
  assign out_data   = slot_r[0];
  assign out_take   = out_valid && !out_stall;
  assign burst_free = (cnt_r == '0) || (cnt_r == spf_pkg::CNT_W'(1) && out_take);
  assign load       = hold_valid_r && burst_free;
  assign in_stall   = hold_valid_r && !burst_free;
  assign in_accept  = in_valid && !in_stall;

  spf_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .item  (hold_r),
    .burst (burst)
  );

  // input register
  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_accept) begin
      hold_valid_nxt = 1'b1;
    end else if (load) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_r <= in_data;
    end
  end

  // burst register: load a whole burst, shift one byte out per take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= burst.count;
    end else if (out_take) begin
      cnt_r <= cnt_r - spf_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= burst.slot;
    end else if (out_take) begin
      for (int i = 0; i < spf_pkg::MAX_RESULTS - 1; i++) begin
        slot_r[i] <= slot_r[i+1];
      end
    end
  end

  // last flag marks exactly the final byte of a burst
  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (cnt_r == spf_pkg::CNT_W'(1))))
    else $error("last flag out of place in burst");

  // a loaded word always puts out at least one byte
  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> cnt_r != '0)
    else $error("empty burst loaded");

  // checksum byte closes the word's burst and is never an error
  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.last && !out_data.error)
    else $error("frame end not on a closing byte");

  // stray payload byte carries zero data
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.out_byte == 8'd0 && out_data.last)
    else $error("error result with data");

endmodule

// File: verif/tb_serial_packet_framer.sv
// Self-checking testbench for the serial packet framer: random packets, backpressure, scoreboard.
`timescale 1ns / 1ps

module tb_serial_packet_framer;

  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 20;   // extra cycles after the last expected byte

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  spf_pkg::in_word_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  spf_pkg::out_word_t out_data;

  // stimulus and scoreboard storage
  spf_pkg::in_word_t  pending_words[$];
  spf_pkg::out_word_t expected_bytes[$];

  // framer state as predicted
  logic [7:0] next_seq = '0;
  logic [7:0] bytes_left = '0;
  logic [7:0] frame_sum = '0;
  logic       frame_open = 1'b0;

  // generator view of the packet being built (payload bytes still owed)
  int unsigned gen_left = 0;

  int unsigned send_idle_pct = 27;
  int unsigned recv_stall_pct = 64;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  logic        word_taken = 1'b0;

  serial_packet_framer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic add_begin(input int unsigned len, input int unsigned code);
    spf_pkg::in_word_t w;
    w.command        = spf_pkg::CMD_BEGIN;
    w.payload_length = len[7:0];
    w.packet_code    = code[7:0];
    w.data_byte      = 8'($urandom_range(0, 255));  // ignored on begin
    pending_words.push_back(w);
    gen_left = len;
  endtask

  task automatic add_payload(input int unsigned data);
    spf_pkg::in_word_t w;
    w.command        = spf_pkg::CMD_PAYLOAD;
    w.payload_length = 8'($urandom_range(0, 255));  // ignored on payload
    w.packet_code    = 8'($urandom_range(0, 255));
    w.data_byte      = data[7:0];
    pending_words.push_back(w);
    if (gen_left > 0) gen_left--;
  endtask

  // Mostly complete packets; some cut short (next begin abandons them), some
  // stray payload bytes between packets.
  task automatic add_random_packets(input int unsigned n_items);
    int unsigned added;
    int unsigned kind;
    int unsigned pick;
    int unsigned len;
    int unsigned sent;
    added = 0;
    while (added < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 10 && gen_left == 0) begin
        add_payload($urandom_range(0, 255));
        added++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 20)      len = 0;
        else if (pick < 85) len = $urandom_range(1, 6);
        else if (pick < 97) len = $urandom_range(7, 20);
        else                len = $urandom_range(21, 60);
        add_begin(len, $urandom_range(0, 255));
        added++;
        // cut the packet short now and then
        sent = (kind >= 88 && len > 0) ? $urandom_range(0, len - 1) : len;
        repeat (sent) add_payload($urandom_range(0, 255));
        added += sent;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void expect_byte(input logic [7:0] b, input logic fend,
                                      input logic lst, input logic err);
    spf_pkg::out_word_t r;
    r.out_byte  = b;
    r.frame_end = fend;
    r.last      = lst;
    r.error     = err;
    expected_bytes.push_back(r);
  endfunction

  // Expected stream bytes for one accepted input word
  function automatic void frame_word(input spf_pkg::in_word_t w);
    logic empty_pkt;
    if (w.command == spf_pkg::CMD_BEGIN) begin
      empty_pkt = (w.payload_length == 8'd0);
      expect_byte(spf_pkg::MAGIC_FIRST, 1'b0, 1'b0, 1'b0);
      expect_byte(spf_pkg::MAGIC_SECOND, 1'b0, 1'b0, 1'b0);
      expect_byte(next_seq, 1'b0, 1'b0, 1'b0);
      expect_byte(w.payload_length, 1'b0, 1'b0, 1'b0);
      expect_byte(w.packet_code, 1'b0, !empty_pkt, 1'b0);
      next_seq   = next_seq + 8'd1;
      frame_sum  = w.payload_length + w.packet_code;
      bytes_left = w.payload_length;
      if (empty_pkt) begin
        // empty packet: checksum follows the header right away
        expect_byte(frame_sum, 1'b1, 1'b1, 1'b0);
        frame_open = 1'b0;
        frame_sum  = '0;
      end else begin
        frame_open = 1'b1;
      end
    end else if (!frame_open) begin
      // stray payload byte, state untouched
      expect_byte(8'd0, 1'b0, 1'b1, 1'b1);
    end else begin
      frame_sum  = frame_sum + w.data_byte;
      bytes_left = bytes_left - 8'd1;
      if (bytes_left == 8'd0) begin
        expect_byte(w.data_byte, 1'b0, 1'b0, 1'b0);
        expect_byte(frame_sum, 1'b1, 1'b1, 1'b0);
        frame_open = 1'b0;
        frame_sum  = '0;
      end else begin
        expect_byte(w.data_byte, 1'b0, 1'b1, 1'b0);
      end
    end
  endfunction

  function automatic void report_mismatch(input string what,
                                          input spf_pkg::out_word_t exp_w,
                                          input spf_pkg::out_word_t got_w);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
               $realtime, what, exp_w.out_byte, exp_w.frame_end, exp_w.last, exp_w.error,
               got_w.out_byte, got_w.frame_end, got_w.last, got_w.error);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: input side changes on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: check output word, then predict from accepted input word
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    spf_pkg::out_word_t exp_w;
    word_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected output word", '0, out_data);
      end else begin
        exp_w = expected_bytes.pop_front();
        if (out_data.out_byte !== exp_w.out_byte || out_data.frame_end !== exp_w.frame_end ||
            out_data.last !== exp_w.last || out_data.error !== exp_w.error)
          report_mismatch("output word mismatch", exp_w, out_data);
      end
    end
    if (rst_n && in_valid && !in_stall) frame_word(in_data);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("serial_packet_framer test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid) @(negedge clk);
    while (expected_bytes.size() != 0) @(negedge clk);
  endtask

  initial begin
    // directed: stray payload bytes right after reset
    add_payload('hFF);
    add_payload('h00);
    // empty packets, smallest and largest code
    add_begin(0, 'h00);
    add_begin(0, 'hFF);
    // one-byte packet whose checksum wraps
    add_begin(1, 'h80);
    add_payload('hFF);
    // longest length, abandoned by the next begin
    add_begin(255, 'hFF);
    add_payload('hFF);
    add_payload('h01);
    add_begin(2, 'h7F);
    add_payload('hAA);
    add_payload('h55);
    // stray after a closed packet
    add_payload('h3C);
    add_begin(3, 'h00);
    add_payload('h00);
    add_payload('hFF);
    add_payload('h80);
    // open packet abandoned by an empty one
    add_begin(5, 'h11);
    add_payload('h22);
    add_begin(0, 'h12);
    add_random_packets(52);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // sender idles little, receiver stalls a lot
    wait_drained();
    @(posedge clk);
    send_idle_pct  = 64;
    recv_stall_pct = 27;
    add_random_packets(52);

    wait_drained();
    @(posedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_random_packets(52);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("serial_packet_framer test passed");
    end else begin
      $display("serial_packet_framer test failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/spf_pkg.sv
hw/rtl/spf_core.sv
hw/rtl/serial_packet_framer.sv
verif/tb_serial_packet_framer.sv
